// ===== hw/rtl/rtc_pkg.sv =====
// ----------------------------------------------------------------------------
// rtc_pkg
// Shared types, register map and BCD helpers for the CMOS RTC register file.
// ----------------------------------------------------------------------------
package rtc_pkg;

    // NVRAM geometry
    localparam int NVRAM_DEPTH = 256;
    localparam int NV_AW       = $clog2(NVRAM_DEPTH);

    // command queue between front and back
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    // time and alarm registers, addresses 0 to 9
    localparam int TIME_REGS = 10;
    localparam int TIME_IW   = $clog2(TIME_REGS);

    // results of one time update
    localparam int UPD_COUNT = 7;
    localparam int UPD_CW    = $clog2(UPD_COUNT);

    // configuration port
    localparam int          CFG_AW      = 3;
    localparam logic [CFG_AW-1:0] CFG_NVRAM_EN = 3'd0;

    // action codes
    localparam logic [1:0] ACT_WRITE  = 2'd0;
    localparam logic [1:0] ACT_READ   = 2'd1;
    localparam logic [1:0] ACT_UPDATE = 2'd2;

    // register map
    localparam logic [7:0] ADDR_SEC     = 8'd0;
    localparam logic [7:0] ADDR_MIN     = 8'd2;
    localparam logic [7:0] ADDR_HOUR    = 8'd4;
    localparam logic [7:0] ADDR_WEEKDAY = 8'd6;
    localparam logic [7:0] ADDR_DAY     = 8'd7;
    localparam logic [7:0] ADDR_MONTH   = 8'd8;
    localparam logic [7:0] ADDR_YEAR    = 8'd9;
    localparam logic [7:0] ADDR_REG_A   = 8'd10;
    localparam logic [7:0] ADDR_REG_B   = 8'd11;
    localparam logic [7:0] ADDR_REG_C   = 8'd12;
    localparam logic [7:0] ADDR_REG_D   = 8'd13;

    // fixed values
    localparam logic [7:0] REG_C_VALUE = 8'h00;
    localparam logic [7:0] REG_D_VALUE = 8'h80;
    localparam logic [7:0] NV_ERASED   = 8'hFF;
    localparam logic [7:0] CTRL_MASK   = 8'h7F;
    localparam logic [7:0] REG_B_FORCE = 8'h02;

    typedef enum logic [2:0] {
        CMD_WR_TIME,
        CMD_WR_REGB,
        CMD_WR_NV,
        CMD_RD_TIME,
        CMD_RD_NV,
        CMD_RD_CONST,
        CMD_UPDATE
    } cmd_kind_t;

    typedef struct packed {
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hour;
        logic [2:0] weekday;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year;
    } time_set_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] addr;
        logic [7:0] data;
        time_set_t  tm;
    } cmd_t;

    // BCD byte to binary, no digit check
    function automatic logic [7:0] from_bcd(input logic [7:0] d);
        logic [7:0] hi8;
        logic [7:0] hi2;
        hi8 = {1'b0, d[7:4], 3'b000};
        hi2 = {3'b000, d[7:4], 1'b0};
        return hi8 + hi2 + {4'b0000, d[3:0]};
    endfunction

    // binary to BCD: v + 6*(v/10), v/10 taken as (v*205)>>11
    function automatic logic [7:0] to_bcd(input logic [7:0] v);
        logic [15:0] p;
        logic [4:0]  q;
        p = {8'h00, v} * 16'd205;
        q = p[15:11];
        return v + {1'b0, q, 2'b00} + {2'b00, q, 1'b0};
    endfunction

    // register address of the k-th result of a time update
    function automatic logic [7:0] upd_addr(input logic [UPD_CW-1:0] k);
        logic [7:0] a;
        case (k)
            3'd0:    a = ADDR_SEC;
            3'd1:    a = ADDR_MIN;
            3'd2:    a = ADDR_HOUR;
            3'd3:    a = ADDR_WEEKDAY;
            3'd4:    a = ADDR_DAY;
            3'd5:    a = ADDR_MONTH;
            default: a = ADDR_YEAR;
        endcase
        return a;
    endfunction

endpackage

// ===== hw/rtl/cmos_rtc_register_file.sv =====
// ----------------------------------------------------------------------------
// cmos_rtc_register_file
// Register file of a CMOS real-time clock: time, alarm and control registers
// plus NVRAM, driven by bus reads, bus writes and time updates.
//
//  Channel   Dir  Payload                                   Handshake
//  s_axis    in   tdata: address..new_year, tuser: action   tvalid/tready
//  m_axis    out  tdata: out_address, out_data; tlast       tvalid/tready
//  APB       in   register 0 at 0x0: nvram_enabled          psel/penable
//
//  The back end takes one item per cycle while the output is not stalled;
//  a time update holds the back end until all seven of its results have
//  passed to the read stage. A read result passes through the command
//  queue, the read stage and the output register to raise m_axis_tvalid.
//  Reset is ready at once: NVRAM erase is tracked by per-entry written flags.
//  A two-entry command queue lets input be taken while output is stalled.
// ----------------------------------------------------------------------------
module cmos_rtc_register_file
    import rtc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // address[7:0], write_data[15:8], new_seconds[21:16], new_minutes[27:22],
    // new_hours[32:28], new_weekday[35:33], new_day[40:36], new_month[44:41],
    // new_year[51:45], zero pad[55:52]
    input  logic [55:0]       s_axis_tdata,
    // action[1:0]
    input  logic [1:0]        s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // out_address[7:0], out_data[15:8]
    output logic [15:0]       m_axis_tdata,
    output logic              m_axis_tlast,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic nvram_enabled_reg;
    logic cfg_wr;
    logic q_push;
    cmd_t q_cmd;
    logic q_full;
    logic q_pop;
    logic q_head_valid;
    cmd_t q_head;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr == CFG_NVRAM_EN) ? {31'h0, nvram_enabled_reg} : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nvram_enabled_reg <= 1'b1;
        end
        else if (cfg_wr && (paddr == CFG_NVRAM_EN))
        begin
            nvram_enabled_reg <= pwdata[0];
        end
    end

    rtc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (q_cmd)
    );

    rtc_cmd_fifo u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    rtc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .nvram_enabled (nvram_enabled_reg),
        .head_valid    (q_head_valid),
        .head          (q_head),
        .pop           (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== hw/rtl/rtc_front.sv =====
// ----------------------------------------------------------------------------
// rtc_front
// Accepts bus transactions, drops repeated writes, writes to registers C and D
// and items with an unknown action, and classifies the rest into commands for the back end.
// ----------------------------------------------------------------------------
module rtc_front
    import rtc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // address[7:0], write_data[15:8], new_seconds[21:16], new_minutes[27:22],
    // new_hours[32:28], new_weekday[35:33], new_day[40:36], new_month[44:41],
    // new_year[51:45], zero pad[55:52]
    input  logic [55:0] s_axis_tdata,
    // action[1:0]
    input  logic [1:0]  s_axis_tuser,
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_cmd
);

    logic [7:0] prev_addr_reg;
    logic [7:0] prev_data_reg;

    logic       accept;
    logic       keep;
    logic       dup;
    logic       wr_new;
    logic [7:0] addr;
    logic [7:0] wdata;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && !q_full;
    assign addr          = s_axis_tdata[7:0];
    assign wdata         = s_axis_tdata[15:8];

    // repeated write to a clock register
    assign dup    = (addr <= ADDR_REG_D) && (addr == prev_addr_reg) &&
                    (wdata == prev_data_reg);
    assign wr_new = (s_axis_tuser == ACT_WRITE) && !dup;

    // classify
    always_comb
    begin
        q_cmd.kind       = CMD_RD_CONST;
        q_cmd.addr       = addr;
        q_cmd.data       = wdata;
        q_cmd.tm.sec     = s_axis_tdata[21:16];
        q_cmd.tm.min     = s_axis_tdata[27:22];
        q_cmd.tm.hour    = s_axis_tdata[32:28];
        q_cmd.tm.weekday = s_axis_tdata[35:33];
        q_cmd.tm.day     = s_axis_tdata[40:36];
        q_cmd.tm.month   = s_axis_tdata[44:41];
        q_cmd.tm.year    = s_axis_tdata[51:45];
        keep             = 1'b0;
        case (s_axis_tuser)
            ACT_WRITE:
            begin
                if (!dup)
                begin
                    if (addr inside {[ADDR_SEC:ADDR_YEAR]})
                    begin
                        q_cmd.kind = CMD_WR_TIME;
                        keep       = 1'b1;
                    end
                    else if (addr == ADDR_REG_A)
                    begin
                        q_cmd.kind = CMD_WR_NV;
                        q_cmd.data = wdata & CTRL_MASK;
                        keep       = 1'b1;
                    end
                    else if (addr == ADDR_REG_B)
                    begin
                        q_cmd.kind = CMD_WR_REGB;
                        q_cmd.data = (wdata | REG_B_FORCE) & CTRL_MASK;
                        keep       = 1'b1;
                    end
                    else if (!(addr inside {ADDR_REG_C, ADDR_REG_D}))
                    begin
                        q_cmd.kind = CMD_WR_NV;
                        keep       = 1'b1;
                    end
                end
            end
            ACT_READ:
            begin
                keep = 1'b1;
                if (addr inside {[ADDR_SEC:ADDR_YEAR]})
                begin
                    q_cmd.kind = CMD_RD_TIME;
                end
                else if (addr == ADDR_REG_C)
                begin
                    q_cmd.kind = CMD_RD_CONST;
                    q_cmd.data = REG_C_VALUE;
                end
                else if (addr == ADDR_REG_D)
                begin
                    q_cmd.kind = CMD_RD_CONST;
                    q_cmd.data = REG_D_VALUE;
                end
                else
                begin
                    q_cmd.kind = CMD_RD_NV;
                end
            end
            ACT_UPDATE:
            begin
                q_cmd.kind = CMD_UPDATE;
                keep       = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign q_push = accept && keep;

    // last accepted write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_addr_reg <= 8'h00;
            prev_data_reg <= 8'h00;
        end
        else if (accept && wr_new)
        begin
            prev_addr_reg <= addr;
            prev_data_reg <= wdata;
        end
    end

endmodule

// ===== hw/rtl/rtc_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// rtc_cmd_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module rtc_cmd_fifo
    import rtc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head
);

    cmd_t               slot_reg [CMDQ_DEPTH];
    logic [CMDQ_PW-1:0] wr_ptr_reg;
    logic [CMDQ_PW-1:0] rd_ptr_reg;
    logic [CMDQ_CW-1:0] count_reg;

    assign full       = (count_reg == CMDQ_CW'(CMDQ_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == CMDQ_PW'(CMDQ_DEPTH - 1)) ? '0 :
                              wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == CMDQ_PW'(CMDQ_DEPTH - 1)) ? '0 :
                              rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/rtc_back.sv =====
// ----------------------------------------------------------------------------
// rtc_back
// Executes commands: owns the clock registers, mode bit and NVRAM, and
// produces results through a read stage and an output register.
// ----------------------------------------------------------------------------
module rtc_back
    import rtc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        nvram_enabled,
    input  logic        head_valid,
    input  cmd_t        head,
    output logic        pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_address[7:0], out_data[15:8]
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    // architectural state
    logic [7:0]        time_reg [TIME_REGS];
    logic              bcd_mode_reg;
    logic              nv_valid_reg [NVRAM_DEPTH];
    logic [7:0]        nv_mem [NVRAM_DEPTH];
    logic [7:0]        nv_rdata_reg;
    logic [UPD_CW-1:0] upd_cnt_reg;

    // read stage
    logic       rd_valid_reg;
    logic [7:0] rd_addr_reg;
    logic [7:0] rd_val_reg;
    logic       rd_from_nv_reg;
    logic       rd_nv_ok_reg;
    logic       rd_bcd_reg;
    logic       rd_last_reg;

    // output register
    logic       out_valid_reg;
    logic [7:0] out_addr_reg;
    logic [7:0] out_data_reg;
    logic       out_last_reg;

    logic              out_free;
    logic              rd_free;
    logic              is_result;
    logic              issue;
    logic              upd_end;
    logic              nv_in_range;
    logic [NV_AW-1:0]  nv_idx;
    logic [TIME_IW-1:0] t_idx;
    logic              nv_wr;
    logic              nv_rd;
    logic [7:0]        time_val;
    logic [7:0]        upd_val;
    logic [7:0]        nv_byte;
    logic [7:0]        rd_result;

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign rd_free   = !rd_valid_reg || out_free;
    assign is_result = (head.kind == CMD_RD_TIME) || (head.kind == CMD_RD_NV) ||
                       (head.kind == CMD_RD_CONST) || (head.kind == CMD_UPDATE);
    assign issue     = head_valid && (!is_result || rd_free);
    assign upd_end   = (upd_cnt_reg == UPD_CW'(UPD_COUNT - 1));
    assign pop       = issue && ((head.kind != CMD_UPDATE) || upd_end);

    assign nv_in_range = ({1'b0, head.addr} < 9'(NVRAM_DEPTH));
    assign nv_idx      = head.addr[NV_AW-1:0];
    assign t_idx       = head.addr[TIME_IW-1:0];
    assign nv_wr       = issue && nvram_enabled && nv_in_range &&
                         ((head.kind == CMD_WR_NV) || (head.kind == CMD_WR_REGB));
    assign nv_rd       = issue && (head.kind == CMD_RD_NV);

    // clock register read and update value select
    always_comb
    begin
        time_val = 8'h00;
        if (head.addr <= ADDR_YEAR)
        begin
            time_val = time_reg[t_idx];
        end
        case (upd_cnt_reg)
            3'd0:    upd_val = {2'b00, head.tm.sec};
            3'd1:    upd_val = {2'b00, head.tm.min};
            3'd2:    upd_val = {3'b000, head.tm.hour};
            3'd3:    upd_val = {5'b00000, head.tm.weekday};
            3'd4:    upd_val = {3'b000, head.tm.day};
            3'd5:    upd_val = {4'b0000, head.tm.month};
            default: upd_val = {1'b0, head.tm.year};
        endcase
    end

    // NVRAM array
    always_ff @(posedge clk)
    begin
        if (nv_wr)
        begin
            nv_mem[nv_idx] <= head.data;
        end
        if (nv_rd)
        begin
            nv_rdata_reg <= nv_mem[nv_idx];
        end
    end

    // written flags, erased until first write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NVRAM_DEPTH; i++)
            begin
                nv_valid_reg[i] <= 1'b0;
            end
        end
        else if (nv_wr)
        begin
            nv_valid_reg[nv_idx] <= 1'b1;
        end
    end

    // clock registers, mode bit, update sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TIME_REGS; i++)
            begin
                time_reg[i] <= 8'h00;
            end
            bcd_mode_reg <= 1'b0;
            upd_cnt_reg  <= '0;
        end
        else if (issue)
        begin
            case (head.kind)
                CMD_WR_TIME:
                begin
                    if (head.addr <= ADDR_YEAR)
                    begin
                        time_reg[t_idx] <= bcd_mode_reg ? from_bcd(head.data) :
                                           head.data;
                    end
                end
                CMD_WR_REGB:
                begin
                    bcd_mode_reg <= !head.data[2];
                end
                CMD_UPDATE:
                begin
                    if (upd_cnt_reg == '0)
                    begin
                        time_reg[TIME_IW'(ADDR_SEC)]     <= {2'b00, head.tm.sec};
                        time_reg[TIME_IW'(ADDR_MIN)]     <= {2'b00, head.tm.min};
                        time_reg[TIME_IW'(ADDR_HOUR)]    <= {3'b000, head.tm.hour};
                        time_reg[TIME_IW'(ADDR_WEEKDAY)] <= {5'b00000, head.tm.weekday};
                        time_reg[TIME_IW'(ADDR_DAY)]     <= {3'b000, head.tm.day};
                        time_reg[TIME_IW'(ADDR_MONTH)]   <= {4'b0000, head.tm.month};
                        time_reg[TIME_IW'(ADDR_YEAR)]    <= {1'b0, head.tm.year};
                    end
                    upd_cnt_reg <= upd_end ? '0 : upd_cnt_reg + 1'b1;
                end
                default:
                begin
                    upd_cnt_reg <= upd_cnt_reg;
                end
            endcase
        end
    end

    // read stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else if (rd_free)
        begin
            rd_valid_reg <= issue && is_result;
        end
    end

    // read stage payload
    always_ff @(posedge clk)
    begin
        if (rd_free && issue && is_result)
        begin
            rd_addr_reg    <= (head.kind == CMD_UPDATE) ? upd_addr(upd_cnt_reg) : head.addr;
            rd_from_nv_reg <= (head.kind == CMD_RD_NV);
            rd_nv_ok_reg   <= nv_valid_reg[nv_idx] && nvram_enabled && nv_in_range;
            rd_bcd_reg     <= bcd_mode_reg &&
                              ((head.kind == CMD_RD_TIME) || (head.kind == CMD_UPDATE));
            rd_last_reg    <= (head.kind != CMD_UPDATE) || upd_end;
            case (head.kind)
                CMD_RD_TIME: rd_val_reg <= time_val;
                CMD_UPDATE:  rd_val_reg <= upd_val;
                default:     rd_val_reg <= head.data;
            endcase
        end
    end

    // host view of the value
    always_comb
    begin
        nv_byte = rd_nv_ok_reg ? nv_rdata_reg : NV_ERASED;
        if (rd_from_nv_reg)
        begin
            if (rd_addr_reg == ADDR_REG_A)
            begin
                rd_result = nv_byte & CTRL_MASK;
            end
            else if (rd_addr_reg == ADDR_REG_B)
            begin
                rd_result = nv_byte | REG_B_FORCE;
            end
            else
            begin
                rd_result = nv_byte;
            end
        end
        else
        begin
            rd_result = rd_bcd_reg ? to_bcd(rd_val_reg) : rd_val_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= rd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && rd_valid_reg)
        begin
            out_addr_reg <= rd_addr_reg;
            out_data_reg <= rd_result;
            out_last_reg <= rd_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_data_reg, out_addr_reg};
    assign m_axis_tlast  = out_last_reg;

    // sequencer only runs with an update at the queue head
    a_upd_head: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_cnt_reg != '0) |-> (head_valid && (head.kind == CMD_UPDATE)))
        else $error("update counter running without update command");

    // a stalled read stage keeps its NVRAM data
    a_rdata_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_valid_reg && rd_from_nv_reg && rd_nv_ok_reg && !out_free) |=>
        $stable(nv_rdata_reg))
        else $error("NVRAM read data lost under stall");

    // only update results go out without last
    a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |->
        ((out_addr_reg == ADDR_SEC) || (out_addr_reg == ADDR_MIN) ||
         (out_addr_reg == ADDR_HOUR) || (out_addr_reg == ADDR_WEEKDAY) ||
         (out_addr_reg == ADDR_DAY) || (out_addr_reg == ADDR_MONTH)))
        else $error("non-final result at unexpected address");

endmodule
